// ===== sv/ryuv420_pkg.sv =====
package ryuv420_pkg;

   // register file
   localparam int unsigned CFG_W = 13;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // 16.16 color conversion coefficients, held at the product width
   localparam int unsigned CSC_W = 25;
   localparam logic [CSC_W-1:0] Y_R  = 25'd19595;
   localparam logic [CSC_W-1:0] Y_G  = 25'd38470;
   localparam logic [CSC_W-1:0] Y_B  = 25'd7471;
   localparam logic [CSC_W-1:0] CB_R = 25'd11056;
   localparam logic [CSC_W-1:0] CB_G = 25'd21712;
   localparam logic [CSC_W-1:0] CB_B = 25'd32768;
   localparam logic [CSC_W-1:0] CR_R = 25'd32768;
   localparam logic [CSC_W-1:0] CR_G = 25'd27440;
   localparam logic [CSC_W-1:0] CR_B = 25'd5328;
   localparam logic [CSC_W-1:0] CHROMA_BIAS = 25'd8388608;

   // line store entry: cb pair sum low, cr pair sum high
   localparam int unsigned PAIR_W = 9;
   localparam int unsigned LINE_W = 2 * PAIR_W;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  luma;
      logic [11:0] out_row;
      logic [11:0] out_col;
      logic        chroma_valid;
      logic [7:0]  cb_out;
      logic [7:0]  cr_out;
      logic        frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } csc_result_type;

endpackage

// ===== sv/rgb_to_yuv420_converter.sv =====
// RGB to YCbCr 4:2:0 converter (BT.601 full range, 16.16 fixed point). Pixels
// arrive in raster order, one per beat, and each gives exactly one result beat
// carrying its luma on a vertically flipped row; on odd rows at odd columns the
// beat also carries the 2x2 averaged Cb/Cr. The block takes one pixel per clock
// while the stages can move, and the result beat is offered once its pixel has
// passed both stages (input register with the line store read, then color
// conversion and chroma pairing into the output register); the two stages fill
// independently, so a stalled result does not block input until both are
// occupied. The line store holds MAX_WIDTH/2 pair sums, is read once at the
// input register and written once as the beat enters the output register, and
// needs no clearing pass after reset. Program frame_width (multiple of 8) and
// frame_height (even) only while the block is idle; the counters restart when a
// new frame size leaves them outside the frame.
module rgb_to_yuv420_converter #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  ryuv420_pkg::req_payload_type             req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output ryuv420_pkg::rsp_payload_type             rsp_payload,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [ryuv420_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ryuv420_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ryuv420_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned WW = CW + 1;
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam int unsigned HW = RW + 1;
   localparam int unsigned IW = CW - 1;
   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
   localparam int unsigned EXT_W = ryuv420_pkg::CFG_W + 1;
   localparam int unsigned PW = ryuv420_pkg::PAIR_W;

   function automatic logic [WW-1:0] clamp_width(input logic [ryuv420_pkg::CFG_W-1:0] value);
      logic [EXT_W-1:0] ext;
      ext = {1'b0, value};
      if (ext < EXT_W'(8)) begin
         ext = EXT_W'(8);
      end else if (ext > EXT_W'(MAX_WIDTH)) begin
         ext = EXT_W'(MAX_WIDTH);
      end
      return WW'(ext & ~EXT_W'(7));
   endfunction

   function automatic logic [HW-1:0] clamp_height(input logic [ryuv420_pkg::CFG_W-1:0] value);
      logic [EXT_W-1:0] ext;
      ext = {1'b0, value};
      if (ext < EXT_W'(2)) begin
         ext = EXT_W'(2);
      end else if (ext > EXT_W'(MAX_HEIGHT)) begin
         ext = EXT_W'(MAX_HEIGHT);
      end
      return HW'(ext & ~EXT_W'(1));
   endfunction

   // configuration
   logic [ryuv420_pkg::CFG_W-1:0] width_reg_ff;
   logic [ryuv420_pkg::CFG_W-1:0] height_reg_ff;
   logic [WW-1:0]                 eff_width_ff;
   logic [HW-1:0]                 eff_height_ff;
   logic                          csr_write;
   ryuv420_pkg::reg_index_type    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = ryuv420_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= ryuv420_pkg::FRAME_WIDTH_RESET;
         height_reg_ff <= ryuv420_pkg::FRAME_HEIGHT_RESET;
         eff_width_ff  <= clamp_width(ryuv420_pkg::FRAME_WIDTH_RESET);
         eff_height_ff <= clamp_height(ryuv420_pkg::FRAME_HEIGHT_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            ryuv420_pkg::REG_FRAME_WIDTH: begin
               width_reg_ff <= csr_pwdata[ryuv420_pkg::CFG_W-1:0];
               eff_width_ff <= clamp_width(csr_pwdata[ryuv420_pkg::CFG_W-1:0]);
            end
            ryuv420_pkg::REG_FRAME_HEIGHT: begin
               height_reg_ff <= csr_pwdata[ryuv420_pkg::CFG_W-1:0];
               eff_height_ff <= clamp_height(csr_pwdata[ryuv420_pkg::CFG_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ryuv420_pkg::REG_FRAME_WIDTH:  csr_prdata = ryuv420_pkg::CSR_DATA_W'(width_reg_ff);
         ryuv420_pkg::REG_FRAME_HEIGHT: csr_prdata = ryuv420_pkg::CSR_DATA_W'(height_reg_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   // stage flow control: a stage moves when it is empty or its successor moves
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic adv2;
   logic adv1;
   logic accept;

   assign adv2      = !rsp_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // raster position
   logic [CW-1:0] col_count_ff;
   logic [RW-1:0] row_count_ff;
   logic [CW-1:0] col_cur;
   logic [RW-1:0] row_cur;
   logic [CW-1:0] col_count_in;
   logic [RW-1:0] row_count_in;
   logic          last_col;
   logic          last_row;
   logic [HW-1:0] flip_row;

   always_comb begin
      col_cur  = ({1'b0, col_count_ff} >= eff_width_ff) ? '0 : col_count_ff;
      row_cur  = ({1'b0, row_count_ff} >= eff_height_ff) ? '0 : row_count_ff;
      last_col = ({1'b0, col_cur} == eff_width_ff - WW'(1));
      last_row = ({1'b0, row_cur} == eff_height_ff - HW'(1));
      flip_row = eff_height_ff - HW'(1) - {1'b0, row_cur};
      col_count_in = last_col ? '0 : col_cur + CW'(1);
      if (!last_col) begin
         row_count_in = row_cur;
      end else if (last_row) begin
         row_count_in = '0;
      end else begin
         row_count_in = row_cur + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // line store of horizontal chroma pair sums from the last even row
   logic [ryuv420_pkg::LINE_W-1:0] line_mem [LINE_DEPTH];
   logic                           line_write;
   logic [IW-1:0]                  line_wr_idx;
   logic [ryuv420_pkg::LINE_W-1:0] line_wr_data;

   // stage 1: input register and line store read
   ryuv420_pkg::req_payload_type   s1_pixel_ff;
   logic [11:0]                    s1_row_ff;
   logic [11:0]                    s1_col_ff;
   logic [IW-1:0]                  s1_idx_ff;
   logic                           s1_odd_col_ff;
   logic                           s1_odd_row_ff;
   logic                           s1_fend_ff;
   logic [ryuv420_pkg::LINE_W-1:0] s1_line_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff   <= req_payload;
         s1_row_ff     <= 12'(flip_row);
         s1_col_ff     <= 12'(col_cur);
         s1_idx_ff     <= col_cur[CW-1:1];
         s1_odd_col_ff <= col_cur[0];
         s1_odd_row_ff <= row_cur[0];
         s1_fend_ff    <= last_col && last_row;
         s1_line_ff    <= line_mem[col_cur[CW-1:1]];
      end
   end

   always_ff @(posedge clock) begin
      if (line_write) begin
         line_mem[line_wr_idx] <= line_wr_data;
      end
   end

   // stage 2: color conversion, chroma pairing and output register
   ryuv420_pkg::csc_result_type  csc_result;
   logic                         move2;
   logic [7:0]                   held_cb_ff;
   logic [7:0]                   held_cr_ff;
   logic [PW-1:0]                cb_pair;
   logic [PW-1:0]                cr_pair;
   logic [PW:0]                  cb_quad;
   logic [PW:0]                  cr_quad;
   logic                         chroma_out;
   ryuv420_pkg::rsp_payload_type rsp_payload_ff;
   ryuv420_pkg::rsp_payload_type rsp_payload_in;

   ryuv420_csc u_csc (
      .pixel  (s1_pixel_ff),
      .result (csc_result)
   );

   assign move2 = adv2 && s1_valid_ff;

   always_comb begin
      cb_pair = PW'(held_cb_ff) + PW'(csc_result.cb);
      cr_pair = PW'(held_cr_ff) + PW'(csc_result.cr);
      cb_quad = (PW+1)'(s1_line_ff[PW-1:0]) + (PW+1)'(cb_pair) + (PW+1)'(2);
      cr_quad = (PW+1)'(s1_line_ff[2*PW-1:PW]) + (PW+1)'(cr_pair) + (PW+1)'(2);
      chroma_out = s1_odd_col_ff && s1_odd_row_ff;

      line_write   = move2 && s1_odd_col_ff && !s1_odd_row_ff;
      line_wr_idx  = s1_idx_ff;
      line_wr_data = {cr_pair, cb_pair};

      rsp_payload_in.luma         = csc_result.luma;
      rsp_payload_in.out_row      = s1_row_ff;
      rsp_payload_in.out_col      = s1_col_ff;
      rsp_payload_in.chroma_valid = chroma_out;
      rsp_payload_in.cb_out       = chroma_out ? cb_quad[PW:2] : 8'd0;
      rsp_payload_in.cr_out       = chroma_out ? cr_quad[PW:2] : 8'd0;
      rsp_payload_in.frame_end    = s1_fend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cb_ff <= '0;
         held_cr_ff <= '0;
      end else if (move2 && !s1_odd_col_ff) begin
         held_cb_ff <= csc_result.cb;
         held_cr_ff <= csc_result.cr;
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== sv/ryuv420_csc.sv =====
module ryuv420_csc (
   input  ryuv420_pkg::req_payload_type pixel,
   output ryuv420_pkg::csc_result_type  result
);

   logic [ryuv420_pkg::CSC_W-1:0] red_ext;
   logic [ryuv420_pkg::CSC_W-1:0] green_ext;
   logic [ryuv420_pkg::CSC_W-1:0] blue_ext;
   logic [ryuv420_pkg::CSC_W-1:0] y_sum;
   logic [ryuv420_pkg::CSC_W-1:0] cb_sum;
   logic [ryuv420_pkg::CSC_W-1:0] cr_sum;

   assign red_ext   = ryuv420_pkg::CSC_W'(pixel.red);
   assign green_ext = ryuv420_pkg::CSC_W'(pixel.green);
   assign blue_ext  = ryuv420_pkg::CSC_W'(pixel.blue);

   // the bias keeps both chroma sums positive for every input
   assign y_sum  = ryuv420_pkg::Y_R * red_ext + ryuv420_pkg::Y_G * green_ext
                 + ryuv420_pkg::Y_B * blue_ext;
   assign cb_sum = ryuv420_pkg::CB_B * blue_ext + ryuv420_pkg::CHROMA_BIAS
                 - ryuv420_pkg::CB_R * red_ext - ryuv420_pkg::CB_G * green_ext;
   assign cr_sum = ryuv420_pkg::CR_R * red_ext + ryuv420_pkg::CHROMA_BIAS
                 - ryuv420_pkg::CR_G * green_ext - ryuv420_pkg::CR_B * blue_ext;

   assign result.luma = y_sum[23:16];
   assign result.cb   = cb_sum[23:16];
   assign result.cr   = cr_sum[23:16];

endmodule

// ===== sv/ryuv420_checker.sv =====
module ryuv420_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input ryuv420_pkg::rsp_payload_type rsp_payload
);

   // chroma fields are zero on beats without a chroma pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.chroma_valid |->
         rsp_payload.cb_out == 8'd0 && rsp_payload.cr_out == 8'd0)
      else $error("chroma fields nonzero without chroma_valid");

   // a chroma pair closes a 2x2 block: odd column, even flipped row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.chroma_valid |->
         rsp_payload.out_col[0] == 1'b1 && rsp_payload.out_row[0] == 1'b0)
      else $error("chroma pair off its block corner");

   // last pixel of a frame sits on flipped row zero at the end of a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_end |->
         rsp_payload.out_row == 12'd0 && rsp_payload.out_col[2:0] == 3'b111
         && rsp_payload.chroma_valid)
      else $error("frame_end on a wrong position");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

endmodule

bind rgb_to_yuv420_converter ryuv420_checker u_ryuv420_checker (.*);

// ===== test/tb_rgb_to_yuv420_converter.sv =====
`timescale 1ns / 100ps

module tb_rgb_to_yuv420_converter;

   localparam int unsigned MAX_FRAME = 4096;
   localparam int unsigned LINE_PAIRS = MAX_FRAME / 2;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned RANDOM_PIXELS = 1050;
   localparam int unsigned HOLD_CYCLES = 250;
   localparam int unsigned HOLD_EVERY = 12000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned MAX_REPORTS = 40;
   localparam int unsigned DIR_ROWS = 26;

   // bt.601 16.16 weights
   localparam int unsigned YR_Q16 = 19595;
   localparam int unsigned YG_Q16 = 38470;
   localparam int unsigned YB_Q16 = 7471;
   localparam int unsigned UR_Q16 = 11056;
   localparam int unsigned UG_Q16 = 21712;
   localparam int unsigned UB_Q16 = 32768;
   localparam int unsigned VR_Q16 = 32768;
   localparam int unsigned VG_Q16 = 27440;
   localparam int unsigned VB_Q16 = 5328;
   localparam int unsigned OFFSET_Q16 = 128 << 16;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   typedef struct packed {
      logic                             reconfig;
      logic [ryuv420_pkg::CFG_W-1:0]    new_width;
      logic [ryuv420_pkg::CFG_W-1:0]    new_height;
      ryuv420_pkg::req_payload_type     px;
      logic                             typed;
      ryuv420_pkg::rsp_payload_type     want;
   } directed_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ryuv420_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ryuv420_pkg::rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ryuv420_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ryuv420_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [ryuv420_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor state
   logic [ryuv420_pkg::CFG_W-1:0] frame_width_cfg = 13'd640;
   logic [ryuv420_pkg::CFG_W-1:0] frame_height_cfg = 13'd480;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned held_cb = 0;
   int unsigned held_cr = 0;
   logic [17:0] pair_sums [LINE_PAIRS];

   ryuv420_pkg::rsp_payload_type yuv_due [$];

   int unsigned mismatches = 0;
   int unsigned pixels_sent = 0;
   int unsigned pixels_checked = 0;
   int unsigned chroma_seen = 0;
   int unsigned settings_used = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;
   int unsigned next_hold = 600;
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   // reset config first, then one full 8x2 frame
   directed_row_type dir_rows [DIR_ROWS] = '{
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 12'd479, 12'd0, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd255, 12'd479, 12'd1, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b1,
        '{8'd76, 12'd479, 12'd2, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd255, 8'd0}, 1'b1,
        '{8'd149, 12'd479, 12'd3, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b1,
        '{8'd29, 12'd479, 12'd4, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd255, 8'd0}, 1'b1,
        '{8'd225, 12'd479, 12'd5, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd255, 8'd255}, 1'b1,
        '{8'd178, 12'd479, 12'd6, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd255}, 1'b1,
        '{8'd105, 12'd479, 12'd7, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd128, 8'd128, 8'd128}, 1'b1,
        '{8'd128, 12'd479, 12'd8, 1'b0, 8'd0, 8'd0, 1'b0}},
      '{1'b0, 13'd0, 13'd0, '{8'd1, 8'd1, 8'd1}, 1'b1,
        '{8'd1, 12'd479, 12'd9, 1'b0, 8'd0, 8'd0, 1'b0}},
      // shrink to the minimum frame: column 10 lies outside and restarts
      '{1'b1, 13'd8, 13'd2, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd255, 8'd255}, 1'b0, '0},
      '{1'b0, 13'd0, 13'd0, '{8'd0, 8'd255, 8'd255}, 1'b0, '0}
   };

   rgb_to_yuv420_converter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch in %s at beat %0d: got 0x%0h, expected 0x%0h",
                  what, pixels_checked, got, want);
   endtask

   function automatic int unsigned active_width();
      int unsigned w;
      w = frame_width_cfg;
      if (w < 8) w = 8;
      if (w > MAX_FRAME) w = MAX_FRAME;
      return w & 32'hFFFF_FFF8;
   endfunction

   function automatic int unsigned active_height();
      int unsigned h;
      h = frame_height_cfg;
      if (h < 2) h = 2;
      if (h > MAX_FRAME) h = MAX_FRAME;
      return h & 32'hFFFF_FFFE;
   endfunction

   // one pixel through the converter: luma, flipped position, 2x2 chroma
   task automatic convert_pixel(input ryuv420_pkg::req_payload_type px,
                                output ryuv420_pkg::rsp_payload_type res);
      int unsigned w, h, r, g, b, y, cb, cr, idx;
      logic [17:0] sums;
      w = active_width();
      h = active_height();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      r = px.red;
      g = px.green;
      b = px.blue;
      y = ((YR_Q16 * r + YG_Q16 * g + YB_Q16 * b) >> 16) & 8'hFF;
      cb = ((UB_Q16 * b + OFFSET_Q16 - UR_Q16 * r - UG_Q16 * g) >> 16) & 8'hFF;
      cr = ((VR_Q16 * r + OFFSET_Q16 - VG_Q16 * g - VB_Q16 * b) >> 16) & 8'hFF;
      res = '0;
      idx = (col_pos >> 1) % LINE_PAIRS;
      if (col_pos % 2 == 0) begin
         held_cb = cb;
         held_cr = cr;
      end else if (row_pos % 2 == 0) begin
         pair_sums[idx] = {9'(held_cr + cr), 9'(held_cb + cb)};
      end else begin
         sums = pair_sums[idx];
         res.cb_out = 8'((32'(sums[8:0]) + held_cb + cb + 2) >> 2);
         res.cr_out = 8'((32'(sums[17:9]) + held_cr + cr + 2) >> 2);
         res.chroma_valid = 1'b1;
      end
      res.luma = 8'(y);
      res.out_row = 12'(h - 1 - row_pos);
      res.out_col = 12'(col_pos);
      res.frame_end = (row_pos == h - 1) && (col_pos == w - 1);
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // one apb transfer; psel stays up so transfers can run back to back
   task automatic csr_access(input ryuv420_pkg::reg_index_type idx, input logic wr,
                             input logic [ryuv420_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [ryuv420_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic program_frame(input logic [ryuv420_pkg::CFG_W-1:0] w,
                                input logic [ryuv420_pkg::CFG_W-1:0] h);
      logic [ryuv420_pkg::CSR_DATA_W-1:0] rd;
      req_valid <= 1'b0;
      while (yuv_due.size() != 0) @(posedge clock);
      csr_access(ryuv420_pkg::REG_FRAME_WIDTH, 1'b1, 32'(w), rd);
      csr_access(ryuv420_pkg::REG_FRAME_HEIGHT, 1'b1, 32'(h), rd);
      csr_access(ryuv420_pkg::REG_FRAME_WIDTH, 1'b0, '0, rd);
      if (rd !== 32'(w)) report_mismatch("frame_width readback", rd, 32'(w));
      csr_access(ryuv420_pkg::REG_FRAME_HEIGHT, 1'b0, '0, rd);
      if (rd !== 32'(h)) report_mismatch("frame_height readback", rd, 32'(h));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      frame_width_cfg = w;
      frame_height_cfg = h;
      settings_used++;
   endtask

   // offers one beat inside a burst, opening a new burst after a random gap
   task automatic send_pixel(input ryuv420_pkg::req_payload_type px, input logic typed,
                             input ryuv420_pkg::rsp_payload_type typed_want);
      int unsigned gap;
      ryuv420_pkg::rsp_payload_type want;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (req_stall);
      burst_left--;
      pixels_sent++;
      convert_pixel(px, want);
      yuv_due.push_back(typed ? typed_want : want);
   endtask

   function automatic logic [7:0] rand_level();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   function automatic ryuv420_pkg::req_payload_type rand_pixel();
      ryuv420_pkg::req_payload_type px;
      px.red = rand_level();
      px.green = rand_level();
      px.blue = rand_level();
      return px;
   endfunction

   function automatic logic [ryuv420_pkg::CFG_W-1:0] pick_width();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 15) return 13'($urandom_range(1, 8) * 8);
      if (sel < 18) return 13'($urandom_range(0, 70));
      return 13'($urandom_range(4097, 8191));
   endfunction

   function automatic logic [ryuv420_pkg::CFG_W-1:0] pick_height();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return 13'($urandom_range(1, 6) * 2);
      if (sel < 17) return 13'($urandom_range(0, 13));
      if (sel < 19) return 13'($urandom_range(4097, 8191));
      return 13'd4096;
   endfunction

   // frames are only resized on an even row so the line store is always
   // filled before an odd row reads it
   task automatic run_frames(input logic [ryuv420_pkg::CFG_W-1:0] w,
                             input logic [ryuv420_pkg::CFG_W-1:0] h,
                             input int unsigned count);
      program_frame(w, h);
      repeat (count) send_pixel(rand_pixel(), 1'b0, '0);
      while (row_pos % 2 != 0) send_pixel(rand_pixel(), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due",
                  cycle_count, yuv_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stall modes plus a periodic long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (cycle_count >= next_hold && req_valid) begin
         hold_left <= HOLD_CYCLES;
         next_hold <= next_hold + HOLD_EVERY;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 96);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      ryuv420_pkg::rsp_payload_type got;
      ryuv420_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_payload;
         if (yuv_due.size() == 0) begin
            report_mismatch("beat with nothing due, luma", 32'(got.luma), '0);
         end else begin
            want = yuv_due.pop_front();
            if (got.luma !== want.luma)
               report_mismatch("luma", 32'(got.luma), 32'(want.luma));
            if (got.out_row !== want.out_row)
               report_mismatch("out_row", 32'(got.out_row), 32'(want.out_row));
            if (got.out_col !== want.out_col)
               report_mismatch("out_col", 32'(got.out_col), 32'(want.out_col));
            if (got.chroma_valid !== want.chroma_valid)
               report_mismatch("chroma_valid", 32'(got.chroma_valid),
                               32'(want.chroma_valid));
            if (got.cb_out !== want.cb_out)
               report_mismatch("cb_out", 32'(got.cb_out), 32'(want.cb_out));
            if (got.cr_out !== want.cr_out)
               report_mismatch("cr_out", 32'(got.cr_out), 32'(want.cr_out));
            if (got.frame_end !== want.frame_end)
               report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
            if (want.chroma_valid) chroma_seen++;
         end
         pixels_checked++;
      end
   end

   initial begin
      logic [ryuv420_pkg::CSR_DATA_W-1:0] rd;
      int unsigned random_pixels;
      random_pixels = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      csr_access(ryuv420_pkg::REG_FRAME_WIDTH, 1'b0, '0, rd);
      if (rd !== 32'd640) report_mismatch("frame_width after reset", rd, 32'd640);
      csr_access(ryuv420_pkg::REG_FRAME_HEIGHT, 1'b0, '0, rd);
      if (rd !== 32'd480) report_mismatch("frame_height after reset", rd, 32'd480);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].reconfig)
            program_frame(dir_rows[i].new_width, dir_rows[i].new_height);
         send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end

      // widest frame for part of a row, then tallest, clamped and below-range sizes
      run_frames(13'd4096, 13'd2, 160);
      run_frames(13'd8, 13'd4096, 64);
      run_frames(13'd8191, 13'd8191, 50);
      run_frames(13'd0, 13'd0, 40);

      while (random_pixels < RANDOM_PIXELS) begin
         rd = $urandom_range(20, 160);
         run_frames(pick_width(), pick_height(), rd);
         random_pixels += rd;
      end

      req_valid <= 1'b0;
      while (yuv_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d pixels, %0d with averaged chroma, over %0d frame settings",
               pixels_checked, chroma_seen, settings_used);
      $display("sizes from 8x2 to 4096x4096 incl. clamped values and restarts on resize");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
